// ===== hw/rtl/tla_pkg.sv =====
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants of the tour length argmin unit: stream layout,
// command codes, length and tour number types, queue entry flags.
// ----------------------------------------------------------------------------
package tla_pkg;

    // stream widths, tdata padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    // field widths fixed by the stream layout
    localparam int IDX_W = 6;
    localparam int NUM_W = 10;
    localparam int LEN_W = 23;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [LEN_W-1:0] len_t;

    // length saturation value
    localparam len_t LEN_MAX = {LEN_W{1'b1}};

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int LEVEL_W     = 3;

    // command codes carried in tuser bit 0
    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_VISIT = 1'b1
    } cmd_t;

    // classification of one visit, travels with its coordinates
    typedef struct packed
    {
        logic idx_ok;
        logic last_tour;
        logic last_batch;
    } visit_flags_t;

    localparam int FLAGS_W = $bits(visit_flags_t);

endpackage

// ===== hw/rtl/tla_ram.sv =====
// ----------------------------------------------------------------------------
// tla_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tla_ram
#(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tla_fifo.sv =====
// ----------------------------------------------------------------------------
// tla_fifo
// Short register queue between front and back, reports its fill level.
// ----------------------------------------------------------------------------
module tla_fifo
#(
    parameter int WIDTH = 35,
    parameter int DEPTH = 4,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic [CNT_W-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign level    = count_reg;

endmodule

// ===== hw/rtl/tla_front.sv =====
// ----------------------------------------------------------------------------
// tla_front
// Input side: accepts stream transactions, writes city coordinates into the
// table, looks up visited cities and hands them to the queue with their flags.
// ----------------------------------------------------------------------------
module tla_front
#(
    parameter int MAX_CITIES = 64,
    parameter int COORD_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tla_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic [tla_pkg::IN_TUSER_W-1:0]  s_tuser,
    // queue side
    input  logic [tla_pkg::LEVEL_W-1:0]     queue_level,
    output logic                            push,
    output tla_pkg::visit_flags_t           push_flags,
    output logic [COORD_BITS-1:0]           push_x,
    output logic [COORD_BITS-1:0]           push_y
);

    localparam int CW        = COORD_BITS;
    localparam int TAB_DEPTH = (MAX_CITIES < 64) ? MAX_CITIES : 64;
    localparam int AW        = $clog2(TAB_DEPTH);

    tla_pkg::cmd_t               cmd;
    logic [tla_pkg::IDX_W-1:0]   idx;
    logic                        idx_ok;
    logic                        accept;
    logic                        wr_en;
    logic                        rd_en;
    logic [CW-1:0]               x_w;
    logic [CW-1:0]               y_w;
    logic [2*CW-1:0]             rd_data;
    logic [tla_pkg::LEVEL_W:0]   in_use;
    logic                        pending_reg;
    tla_pkg::visit_flags_t       flags_reg;

    // field decode
    assign cmd    = tla_pkg::cmd_t'(s_tuser[0]);
    assign idx    = s_tdata[5:0];
    assign idx_ok = ({1'b0, idx} < (tla_pkg::IDX_W + 1)'(TAB_DEPTH));

    // keep the low coordinate bits; wider coordinates are zero-extended
    generate
        if (CW <= 16)
        begin : g_narrow
            assign x_w = s_tdata[6 +: CW];
            assign y_w = s_tdata[22 +: CW];
        end
        else
        begin : g_wide
            assign x_w = {{(CW-16){1'b0}}, s_tdata[21:6]};
            assign y_w = {{(CW-16){1'b0}}, s_tdata[37:22]};
        end
    endgenerate

    // accept only while the queue has room for every lookup in flight
    assign in_use   = {1'b0, queue_level} + (tla_pkg::LEVEL_W + 1)'(pending_reg);
    assign s_tready = (in_use < (tla_pkg::LEVEL_W + 1)'(tla_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    assign wr_en = accept && (cmd == tla_pkg::CMD_LOAD) && idx_ok;
    assign rd_en = accept && (cmd == tla_pkg::CMD_VISIT);

    // coordinate table, x in the upper half
    tla_ram
    #(
        .WIDTH (2 * CW),
        .DEPTH (TAB_DEPTH)
    )
    u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx[AW-1:0]),
        .wr_data ({x_w, y_w}),
        .rd_en   (rd_en),
        .rd_addr (idx[AW-1:0]),
        .rd_data (rd_data)
    );

    // lookup in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            flags_reg.idx_ok     <= idx_ok;
            flags_reg.last_tour  <= s_tlast;
            flags_reg.last_batch <= s_tuser[1];
        end
    end

    // out of range cities read as the origin
    assign push       = pending_reg;
    assign push_flags = flags_reg;
    assign push_x     = flags_reg.idx_ok ? rd_data[2*CW-1:CW] : '0;
    assign push_y     = flags_reg.idx_ok ? rd_data[CW-1:0]    : '0;

endmodule

// ===== hw/rtl/tla_back.sv =====
// ----------------------------------------------------------------------------
// tla_back
// Execution side: hop distances, running tour length, best tour selection
// and the output register. Three stages that advance together.
// ----------------------------------------------------------------------------
module tla_back
#(
    parameter int MAX_TOURS  = 1024,
    parameter int COORD_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // queue side
    input  logic                            queue_empty,
    output logic                            pop,
    input  tla_pkg::visit_flags_t           pop_flags,
    input  logic [COORD_BITS-1:0]           pop_x,
    input  logic [COORD_BITS-1:0]           pop_y,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tla_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int CW = COORD_BITS;
    localparam int SW = (CW + 2 > tla_pkg::LEN_W + 1) ? CW + 2 : tla_pkg::LEN_W + 1;
    localparam tla_pkg::num_t TOUR_CAP =
        tla_pkg::num_t'((MAX_TOURS < 1024) ? MAX_TOURS - 1 : 1023);

    // saturated |dx|+|dy|
    function automatic tla_pkg::len_t hop(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                          input logic [CW-1:0] bx, input logic [CW-1:0] by);
        logic [CW:0]   dx;
        logic [CW:0]   dy;
        logic [CW:0]   mx;
        logic [CW:0]   my;
        logic [SW-1:0] s;
        dx  = {ax[CW-1], ax} - {bx[CW-1], bx};
        dy  = {ay[CW-1], ay} - {by[CW-1], by};
        mx  = dx[CW] ? (~dx + 1'b1) : dx;
        my  = dy[CW] ? (~dy + 1'b1) : dy;
        s   = SW'(mx) + SW'(my);
        hop = (s > SW'(tla_pkg::LEN_MAX)) ? tla_pkg::LEN_MAX : s[tla_pkg::LEN_W-1:0];
    endfunction

    // saturated length sum
    function automatic tla_pkg::len_t sat_add(input tla_pkg::len_t a, input tla_pkg::len_t b);
        logic [tla_pkg::LEN_W:0] s;
        s       = {1'b0, a} + {1'b0, b};
        sat_add = s[tla_pkg::LEN_W] ? tla_pkg::LEN_MAX : s[tla_pkg::LEN_W-1:0];
    endfunction

    logic              enable;

    // stage a: hop unit state
    logic              in_tour_reg;
    logic [CW-1:0]     first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [CW-1:0]     first_x_next, first_y_next;
    logic              valid_a_reg;
    logic              start_a_reg, last_tour_a_reg, last_batch_a_reg;
    tla_pkg::len_t     hop_prev_a_reg, hop_close_a_reg;

    // stage b: running length
    tla_pkg::len_t     run_reg, run_next;
    tla_pkg::len_t     len_next;
    logic              valid_b_reg;
    logic              last_batch_b_reg;
    tla_pkg::len_t     len_b_reg;

    // stage c: selection and output register
    tla_pkg::num_t     count_reg;
    tla_pkg::len_t     best_len_reg, best_len_next;
    tla_pkg::num_t     best_idx_reg, best_idx_next;
    logic              better;
    logic              out_valid_reg;
    tla_pkg::num_t     out_num_reg, out_best_idx_reg;
    tla_pkg::len_t     out_len_reg, out_best_len_reg;
    logic              out_last_reg;

    // the whole back pipeline holds while a result waits
    assign enable = !out_valid_reg || m_tready;
    assign pop    = enable && !queue_empty;

    // first city of a tour becomes the closing point
    assign first_x_next = in_tour_reg ? first_x_reg : pop_x;
    assign first_y_next = in_tour_reg ? first_y_reg : pop_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_tour_reg <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            valid_a_reg <= 1'b0;
        end
        else
        begin
            if (enable)
            begin
                valid_a_reg <= pop;
            end
            if (pop)
            begin
                in_tour_reg <= !pop_flags.last_tour;
                first_x_reg <= first_x_next;
                first_y_reg <= first_y_next;
                prev_x_reg  <= pop_x;
                prev_y_reg  <= pop_y;
            end
        end
    end

    // both hops of this city in parallel
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            start_a_reg      <= !in_tour_reg;
            last_tour_a_reg  <= pop_flags.last_tour;
            last_batch_a_reg <= pop_flags.last_batch;
            hop_prev_a_reg   <= hop(prev_x_reg, prev_y_reg, pop_x, pop_y);
            hop_close_a_reg  <= hop(pop_x, pop_y, first_x_next, first_y_next);
        end
    end

    // running length and closed length
    assign run_next = start_a_reg ? '0 : sat_add(run_reg, hop_prev_a_reg);
    assign len_next = sat_add(run_next, hop_close_a_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            valid_b_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_b_reg <= valid_a_reg && last_tour_a_reg;
            if (valid_a_reg)
            begin
                run_reg <= last_tour_a_reg ? '0 : run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && valid_a_reg)
        begin
            len_b_reg        <= len_next;
            last_batch_b_reg <= last_batch_a_reg;
        end
    end

    // best tour, strictly shorter replaces
    assign better        = (len_b_reg < best_len_reg);
    assign best_len_next = better ? len_b_reg : best_len_reg;
    assign best_idx_next = better ? count_reg : best_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            best_len_reg  <= tla_pkg::LEN_MAX;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            out_valid_reg <= valid_b_reg;
            if (valid_b_reg)
            begin
                if (last_batch_b_reg)
                begin
                    count_reg    <= '0;
                    best_len_reg <= tla_pkg::LEN_MAX;
                    best_idx_reg <= '0;
                end
                else
                begin
                    best_len_reg <= best_len_next;
                    best_idx_reg <= best_idx_next;
                    if (count_reg < TOUR_CAP)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (enable && valid_b_reg)
        begin
            out_num_reg      <= count_reg;
            out_len_reg      <= len_b_reg;
            out_best_idx_reg <= best_idx_next;
            out_best_len_reg <= best_len_next;
            out_last_reg     <= last_batch_b_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_best_len_reg, out_best_idx_reg, out_len_reg, out_num_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/tour_length_argmin_unit.sv =====
// ----------------------------------------------------------------------------
// tour_length_argmin_unit
// Scores closed tours by L1 length and reports the shortest of each batch.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction per item. tuser[0] is the command: a load
// writes the x,y coordinate of a city into the table, a visit names the next
// city of the current tour. s_tlast marks the last city of a tour, tuser[1]
// on that city marks the last tour of a batch.
// Output stream m_*: one transaction per finished tour with tour number,
// closed length, best index and best length so far; m_tlast marks the batch
// end, after which numbering and best values start over.
// Throughput: one item per cycle while the receiver does not stall. A result
// travels from the accepted last city through the table read, queue, hop
// stage, length stage and output register.
// The table lookup and the three back stages are decoupled by a 4-entry
// queue; when the receiver stalls, the back stages hold, the queue fills and
// s_tready drops once the queue and the lookup in flight reach its depth.
// Reset clears tour state, tour counter and best values; the coordinate
// table needs no clearing and must be loaded before its cities are visited.
// ----------------------------------------------------------------------------
module tour_length_argmin_unit
#(
    parameter int MAX_CITIES = 64,
    parameter int MAX_TOURS  = 1024,
    parameter int COORD_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // city_index[5:0], x_coord[21:6], y_coord[37:22], zero pad
    input  logic [tla_pkg::IN_TDATA_W-1:0]  s_tdata,
    // last_in_tour
    input  logic                            s_tlast,
    // command[0], last_in_batch[1]
    input  logic [tla_pkg::IN_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tour_number[9:0], tour_length[32:10], best_index[42:33],
    // best_length[65:43], zero pad
    output logic [tla_pkg::OUT_TDATA_W-1:0] m_tdata,
    // batch_done
    output logic                            m_tlast
);

    localparam int QW = tla_pkg::FLAGS_W + 2 * COORD_BITS;

    logic                          push;
    tla_pkg::visit_flags_t         push_flags;
    logic [COORD_BITS-1:0]         push_x, push_y;
    logic                          pop;
    logic [QW-1:0]                 pop_data;
    logic                          queue_empty;
    logic [tla_pkg::LEVEL_W-1:0]   queue_level;
    tla_pkg::visit_flags_t         pop_flags;

    // accept, table and classification
    tla_front
    #(
        .MAX_CITIES (MAX_CITIES),
        .COORD_BITS (COORD_BITS)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .queue_level (queue_level),
        .push        (push),
        .push_flags  (push_flags),
        .push_x      (push_x),
        .push_y      (push_y)
    );

    // visit queue
    tla_fifo
    #(
        .WIDTH (QW),
        .DEPTH (tla_pkg::QUEUE_DEPTH),
        .CNT_W (tla_pkg::LEVEL_W)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_flags, push_x, push_y}),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty),
        .level     (queue_level)
    );

    assign pop_flags = tla_pkg::visit_flags_t'(pop_data[QW-1:2*COORD_BITS]);

    // lengths, selection, output register
    tla_back
    #(
        .MAX_TOURS  (MAX_TOURS),
        .COORD_BITS (COORD_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_flags   (pop_flags),
        .pop_x       (pop_data[2*COORD_BITS-1:COORD_BITS]),
        .pop_y       (pop_data[COORD_BITS-1:0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== hw/rtl/tla_checker.sv =====
// ----------------------------------------------------------------------------
// tla_checker
// Port-level checks on the result stream of the tour length argmin unit.
// ----------------------------------------------------------------------------
module tla_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tla_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast
);

    logic          out_xfer;
    logic          batch_start_reg;
    tla_pkg::num_t tour_number, best_index;
    tla_pkg::len_t tour_length, best_length;

    assign out_xfer    = m_tvalid && m_tready;
    assign tour_number = m_tdata[9:0];
    assign tour_length = m_tdata[32:10];
    assign best_index  = m_tdata[42:33];
    assign best_length = m_tdata[65:43];

    // next result opens a batch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_start_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            batch_start_reg <= m_tlast;
        end
    end

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // best length never exceeds the tour just reported
    a_best_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> best_length <= tour_length)
        else $error("best length above tour length");

    // best tour is this one or an earlier one
    a_best_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> best_index <= tour_number)
        else $error("best index ahead of tour number");

    // numbering restarts after a batch end
    a_batch_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && batch_start_reg |-> tour_number == '0 && best_index == '0)
        else $error("tour numbering did not restart");

endmodule

bind tour_length_argmin_unit tla_checker u_tla_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
